[src/gcq_pkg.sv]
// Package for the group cutting queue: transaction structs, cell types,
// command and status codes. No dependencies.
package gcq_pkg;

   localparam int PERSON_W     = 8;
   localparam int GROUP_W      = 5;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int PERSON_COUNT = 1 << PERSON_W;

   localparam logic [GROUP_W-1:0] NO_GROUP   = 5'd31;
   localparam logic [GROUP_W-1:0] MAX_GROUPS = 5'd26;

   localparam logic [CMD_W-1:0] CMD_ASSIGN  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [PERSON_W-1:0] person;
      logic [GROUP_W-1:0]  group_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PERSON_W-1:0] out_person;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [PERSON_W-1:0] person;
      logic [GROUP_W-1:0]  group;
   } cell_data_type;

   typedef struct packed {
      logic ins;
      logic deq;
   } cell_ctl_type;

endpackage

[src/group_cutting_queue_core.sv]
// Group cutting queue, top level: request register, control, group table
// and a chain of gcq_cell slots. Uses gcq_pkg, gcq_cell, gcq_group_table.
//
// Usage: each request transaction on req_ (valid/ready) carries a command:
// assign a person to a group, enqueue a person, or dequeue the head. Every
// request gives exactly one response transaction on rsp_ with a status and,
// for a dequeue, the person removed from the head.
// An enqueued person with a group is placed directly in front of the
// earliest queued member of that group, otherwise at the tail. An enqueue
// into a full queue is dropped with status full.
// The request is registered and the group table is read at the accepting
// edge; the slots and the response register update when the response
// register is free. req_ready is high while the control is idle, also
// while an earlier response still waits; no request is taken in execution.
// When rsp_ready stays low, the finished response holds in its output
// register and the next request waits in the update cycle until the
// register frees up.
// Reset empties the queue and clears every person's group; the block is
// ready right after.
module group_cutting_queue_core #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gcq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gcq_pkg::rsp_type rsp_payload
);
   import gcq_pkg::*;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_EXEC = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               done;
   logic               full;
   logic               empty;
   logic [GROUP_W-1:0] lookup_group;
   logic               tbl_wr_en;
   cell_ctl_type       ctl;
   cell_data_type      new_data;
   cell_data_type      cell_q [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] chain;

   assign req_ready   = (state_ff == STATE_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign done  = (state_ff == STATE_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full  = cell_q[QUEUE_DEPTH-1].valid;
   assign empty = !cell_q[0].valid;

   assign ctl.ins = done && req_ff.command == CMD_ENQUEUE && !full;
   assign ctl.deq = done && req_ff.command == CMD_DEQUEUE && !empty;
   assign tbl_wr_en = done && req_ff.command == CMD_ASSIGN &&
                      lookup_group == NO_GROUP && req_ff.group_id < MAX_GROUPS;

   assign new_data.valid  = 1'b1;
   assign new_data.person = req_ff.person;
   assign new_data.group  = lookup_group;

   gcq_group_table u_group_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_payload.person),
      .rd_group (lookup_group),
      .wr_en    (tbl_wr_en),
      .wr_addr  (req_ff.person),
      .wr_data  (req_ff.group_id)
   );

   assign chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_data_type left_data;
      cell_data_type right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_body
         assign left_data = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cell_q[i+1];
      end

      gcq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_data   (new_data),
         .left_data  (left_data),
         .right_data (right_data),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .data       (cell_q[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               req_in   = req_payload;
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (done) begin
               rsp_in.status     = ST_OK;
               rsp_in.out_person = '0;
               case (req_ff.command)
                  CMD_ENQUEUE: begin
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_in.status     = ST_DEQ;
                        rsp_in.out_person = cell_q[0].person;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_OK;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

[src/gcq_cell.sv]
// One queue slot of the group cutting queue: holds a person and its group,
// takes data from either neighbor on insert or dequeue. Uses gcq_pkg.
module gcq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gcq_pkg::cell_ctl_type ctl,
   input  gcq_pkg::cell_data_type new_data,
   input  gcq_pkg::cell_data_type left_data,
   input  gcq_pkg::cell_data_type right_data,
   input  logic                  chain_in,
   output logic                  chain_out,
   output gcq_pkg::cell_data_type data
);
   import gcq_pkg::*;

   cell_data_type data_ff;
   cell_data_type data_in;
   logic          stop;

   // Insert point: first free slot or first slot of the same group.
   assign stop = !data_ff.valid ||
                 (data_ff.group == new_data.group && new_data.group != NO_GROUP);
   assign chain_out = chain_in | stop;
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (chain_in) begin
            data_in = left_data;
         end else if (stop) begin
            data_in = new_data;
         end
      end else if (ctl.deq) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.person <= data_in.person;
      data_ff.group  <= data_in.group;
   end

endmodule

[src/gcq_group_table.sv]
// Person-to-group table: a memory with one valid bit per person; an entry
// never written reads as no group. Uses gcq_pkg.
module gcq_group_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [gcq_pkg::PERSON_W-1:0] rd_addr,
   output logic [gcq_pkg::GROUP_W-1:0]  rd_group,
   input  logic                         wr_en,
   input  logic [gcq_pkg::PERSON_W-1:0] wr_addr,
   input  logic [gcq_pkg::GROUP_W-1:0]  wr_data
);
   import gcq_pkg::*;

   logic [GROUP_W-1:0]      group_mem [PERSON_COUNT];
   logic [PERSON_COUNT-1:0] valid_ff;
   logic [PERSON_COUNT-1:0] valid_in;
   logic [GROUP_W-1:0]      rd_data_ff;
   logic                    rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         group_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= group_mem[rd_addr];
      end
   end

   assign rd_group = rd_valid_ff ? rd_data_ff : NO_GROUP;

endmodule
